### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, inactive while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Concurrent assertion, also checked through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### sv/tlvd_pkg.sv
`default_nettype none
package tlvd_pkg;

    localparam int TLVD_Q_DEPTH = 4;
    localparam int TLVD_Q_AW    = $clog2(TLVD_Q_DEPTH);
    localparam int TLVD_Q_CW    = $clog2(TLVD_Q_DEPTH + 1);

    localparam logic [7:0] LONG_LEN_MIN = 8'h81;
    localparam logic [7:0] LONG_LEN_MAX = 8'h84;

    // one command from the parser to the emitter
    typedef struct packed {
        logic       clr;    // forget the last element before this command
        logic       empty;  // zero-length record, may be dropped
        logic [7:0] tag;
        logic [7:0] data;
        logic       last;
    } t_cmd;

endpackage
`default_nettype wire

### sv/tlvd_ifs.sv
`default_nettype none
interface tlvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_message;

    modport source (output valid, output in_byte, output start_message, input ready);
    modport sink   (input valid, input in_byte, input start_message, output ready);
endinterface

interface tlvd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_tag;
    logic [7:0] out_byte;
    logic       out_new_element;
    logic       out_empty_element;
    logic       out_record_end;

    modport source (output valid, output out_tag, output out_byte, output out_new_element,
                    output out_empty_element, output out_record_end, input ready);
    modport sink   (input valid, input out_tag, input out_byte, input out_new_element,
                    input out_empty_element, input out_record_end, output ready);
endinterface
`default_nettype wire

### sv/tlvd_front.sv
`default_nettype none
module tlvd_front #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_start,
    output logic               o_push,
    output tlvd_pkg::t_cmd     o_cmd
);
    import tlvd_pkg::*;

    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_LONGLEN = 2'd2;
    localparam logic [1:0] PH_VALUE   = 2'd3;

    logic                    r_ber;
    logic [1:0]              r_phase, n_phase;
    logic [7:0]              r_tag, n_tag;
    logic [LENGTH_WIDTH-1:0] r_left, n_left;
    logic [2:0]              r_lbl, n_lbl;
    logic                    r_clr_pend, n_clr_pend;
    logic [1:0]              phase_eff;
    logic [LENGTH_WIDTH+7:0] shl;
    logic                    push;
    logic                    push_empty;

    assign shl = {r_left, i_byte};

    always_comb begin
        phase_eff  = i_start ? PH_TAG : r_phase;
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_left     = i_start ? '0 : r_left;
        n_lbl      = i_start ? 3'd0 : r_lbl;
        push       = 1'b0;
        push_empty = 1'b0;
        case (phase_eff)
            PH_TAG: begin
                n_tag   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_byte == 8'h00) begin
                    push       = 1'b1;
                    push_empty = 1'b1;
                    n_phase    = PH_TAG;
                end else if (r_ber && (i_byte inside {[LONG_LEN_MIN:LONG_LEN_MAX]})) begin
                    n_lbl   = i_byte[2:0];
                    n_left  = '0;
                    n_phase = PH_LONGLEN;
                end else begin
                    n_left  = LENGTH_WIDTH'(i_byte);
                    n_phase = PH_VALUE;
                end
            end
            PH_LONGLEN: begin
                n_left = shl[LENGTH_WIDTH-1:0];
                if (r_lbl != 3'd0) begin
                    n_lbl = r_lbl - 3'd1;
                end
                if (n_lbl == 3'd0) begin
                    if (n_left == '0) begin
                        push       = 1'b1;
                        push_empty = 1'b1;
                        n_phase    = PH_TAG;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            default: begin
                push = 1'b1;
                if (r_left != '0) begin
                    n_left = r_left - LENGTH_WIDTH'(1);
                end
                if (n_left == '0) begin
                    n_phase = PH_TAG;
                end
            end
        endcase
    end

    // a start beat never pushes, so its clear rides on the next command
    always_comb begin
        n_clr_pend = r_clr_pend;
        if (i_accept) begin
            if (i_start) begin
                n_clr_pend = 1'b1;
            end else if (push) begin
                n_clr_pend = 1'b0;
            end
        end
    end

    assign o_push      = i_accept && push;
    assign o_cmd.clr   = r_clr_pend;
    assign o_cmd.empty = push_empty;
    assign o_cmd.tag   = r_tag;
    assign o_cmd.data  = push_empty ? 8'h00 : i_byte;
    assign o_cmd.last  = push_empty || (r_left <= LENGTH_WIDTH'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ber      <= 1'b0;
            r_phase    <= PH_TAG;
            r_tag      <= 8'h00;
            r_left     <= '0;
            r_lbl      <= 3'd0;
            r_clr_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ber <= i_cfg_wdata;
            end
            r_clr_pend <= n_clr_pend;
            if (i_accept) begin
                r_phase <= n_phase;
                r_tag   <= n_tag;
                r_left  <= n_left;
                r_lbl   <= n_lbl;
            end
        end
    end

endmodule
`default_nettype wire

### sv/tlvd_cmd_fifo.sv
`default_nettype none
module tlvd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tlvd_pkg::t_cmd i_cmd,
    output logic               o_ready,
    output logic               o_valid,
    output tlvd_pkg::t_cmd     o_cmd,
    input  wire logic          i_pop
);
    import tlvd_pkg::*;

    t_cmd                 r_mem [TLVD_Q_DEPTH];
    logic [TLVD_Q_AW-1:0] r_wptr;
    logic [TLVD_Q_AW-1:0] r_rptr;
    logic [TLVD_Q_CW-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_ready = (r_count < TLVD_Q_CW'(TLVD_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + TLVD_Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + TLVD_Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + TLVD_Q_CW'(1);
                2'b01:   r_count <= r_count - TLVD_Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/tlvd_back.sv
`default_nettype none
module tlvd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire tlvd_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_tag,
    output logic [7:0]         o_byte,
    output logic               o_new_element,
    output logic               o_empty_element,
    output logic               o_record_end
);
    import tlvd_pkg::*;

    logic       r_valid;
    logic [7:0] r_prev_tag;
    logic       r_prev_valid;
    logic       take;
    logic       match;
    logic       emit;

    assign take      = !r_valid || i_ready;
    assign o_cmd_pop = i_cmd_valid && take;
    assign match     = !i_cmd.clr && r_prev_valid && (r_prev_tag == i_cmd.tag);
    // zero-length record on the current element's tag produces nothing
    assign emit      = !(i_cmd.empty && match);
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_prev_tag   <= 8'h00;
            r_prev_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= o_cmd_pop && emit;
            end
            if (o_cmd_pop) begin
                r_prev_tag   <= i_cmd.tag;
                r_prev_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            o_tag           <= i_cmd.tag;
            o_byte          <= i_cmd.data;
            o_new_element   <= !match;
            o_empty_element <= i_cmd.empty;
            o_record_end    <= i_cmd.last;
        end
    end

endmodule
`default_nettype wire

### sv/tlv_record_deframer_unit.sv
`default_nettype none
// TLV record deframer.
// i_in carries one stream byte per beat (in_byte, start_message); start_message
// drops any partial record and the merge memory, and its byte is taken as a tag.
// o_out carries one result per value byte, plus one empty-element result for a
// zero-length record whose tag differs from the last element's tag.
// i_cfg_we / i_cfg_wdata write ber_enable (long-form lengths 0x81..0x84).
// Throughput: one input beat per cycle, sustained, with o_out.ready held high.
// A value byte passes the command queue, then the emitter's output register.
// The parser and emitter are joined by a 4-entry command queue; i_in.ready
// depends only on queue occupancy, so a stall on o_out holds the output
// register and backs the queue up; input stops after 4 queued commands. Tag,
// length, long-length beats push only for an empty record and flow until then.
// Reset (synchronous, active low) empties the queue and output, clears
// ber_enable and returns the parser to expecting a tag with no last element.
module tlv_record_deframer_unit #(
    parameter int LENGTH_WIDTH = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic    i_cfg_wdata,
    tlvd_in_if.sink      i_in,
    tlvd_out_if.source   o_out
);
    import tlvd_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic front_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    logic in_accept;

    assign i_in.ready = q_ready;
    assign in_accept  = i_in.valid && q_ready;

    tlvd_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_byte      (i_in.in_byte),
        .i_start     (i_in.start_message),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    tlvd_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    tlvd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (q_pop),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_tag           (o_out.out_tag),
        .o_byte          (o_out.out_byte),
        .o_new_element   (o_out.out_new_element),
        .o_empty_element (o_out.out_empty_element),
        .o_record_end    (o_out.out_record_end)
    );

endmodule
`default_nettype wire

### sv/tlvd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tlvd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_tag,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_new,
    input wire logic       i_out_empty,
    input wire logic       i_out_end
);

    logic        r_seen;
    logic [7:0]  r_last_tag;
    logic        stalled;
    logic [18:0] out_beat;
    logic        empty_ok;
    logic        append_ok;

    assign stalled   = i_out_valid && !i_out_ready;
    assign out_beat  = {i_out_tag, i_out_byte, i_out_new, i_out_empty, i_out_end};
    assign empty_ok  = i_out_new && i_out_end && (i_out_byte == 8'h00);
    assign append_ok = r_seen && (i_out_tag == r_last_tag);

    // tag of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_tag <= 8'h00;
        end else if (i_out_valid && i_out_ready) begin
            r_seen     <= 1'b1;
            r_last_tag <= i_out_tag;
        end
    end

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, stalled |=> i_out_valid && $stable(out_beat))
    `ASSERT_RST(a_empty_shape, i_clk, i_rst_n, i_out_valid && i_out_empty |-> empty_ok)
    `ASSERT_RST(a_append_same_tag, i_clk, i_rst_n, i_out_valid && !i_out_new |-> append_ok)
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind tlv_record_deframer_unit tlvd_checker u_tlvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_tag   (o_out.out_tag),
    .i_out_byte  (o_out.out_byte),
    .i_out_new   (o_out.out_new_element),
    .i_out_empty (o_out.out_empty_element),
    .i_out_end   (o_out.out_record_end)
);
`default_nettype wire
